// ===== hw/rtl/dewf_pkg.sv =====
// Shared types, character codes and compare helpers for the directory entry filter.
// No dependencies; imported by every module of the filter.
`default_nettype none

package dewf_pkg;

    // Character codes
    localparam logic [7:0] CH_DELETED = 8'hE5;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_NAME_PATTERN = 2'd0;
    localparam logic [1:0]  CFG_EXT_PATTERN  = 2'd1;
    localparam logic [1:0]  CFG_SKIP_DELETED = 2'd2;

    // Register reset values
    localparam logic [63:0] NAME_PATTERN_RST = 64'd42;
    localparam logic [23:0] EXT_PATTERN_RST  = 24'd42;
    localparam logic        SKIP_DELETED_RST = 1'b1;

    // Per-position compare classes of one field (pattern against entry)
    typedef struct packed {
        logic [7:0] star;   // pattern byte is '*'
        logic [7:0] qmark;  // pattern byte is '?'
        logic [7:0] term;   // wildcard walk stops here unless '*' or '?'
        logic [7:0] hit;    // both bytes are the terminator
        logic       exact;  // all masked bytes agree
        logic       wild;   // pattern holds a wildcard
    } fld_class_t;

    // Stage 1 -> stage 2
    typedef struct packed {
        fld_class_t  name_c;
        fld_class_t  ext_c;
        logic        ext_pat_empty;
        logic        ext_first_space;
        logic        long_name;
        logic        dir_end;
        logic        deleted;
        logic [7:0]  attrib;
        logic [15:0] cluster;
        logic [31:0] size;
    } s1_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic        name_ok;
        logic        ext_ok;
        logic        long_name;
        logic        dir_end;
        logic        deleted;
        logic [7:0]  attrib;
        logic [15:0] cluster;
        logic [31:0] size;
    } s2_t;

    // Zero every byte from the first terminator on (zero, or space if asked)
    function automatic logic [63:0] mask_field(input logic [63:0] v, input logic stop_space);
        logic        live;
        logic [7:0]  b;
        logic [63:0] r;
        live = 1'b1;
        r    = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = v[8*i +: 8];
            if (b == 8'h00 || (stop_space && b == CH_SPACE))
                live = 1'b0;
            r[8*i +: 8] = live ? b : 8'h00;
        end
        return r;
    endfunction

    // Classify each position of a masked pattern against a masked entry field
    function automatic fld_class_t classify_field(input logic [63:0] p, input logic [63:0] s);
        fld_class_t c;
        logic [7:0] pc;
        logic [7:0] sc;
        c       = '0;
        c.exact = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            pc         = p[8*i +: 8];
            sc         = s[8*i +: 8];
            c.star[i]  = (pc == CH_STAR);
            c.qmark[i] = (pc == CH_QMARK);
            c.term[i]  = (pc != sc) || (pc == 8'h00);
            c.hit[i]   = (pc == sc) && (pc == 8'h00);
            c.exact    = c.exact && (pc == sc);
            c.wild     = c.wild || c.star[i] || c.qmark[i];
        end
        return c;
    endfunction

    // Wildcard walk: the first '*' or stopping position decides; running off the end matches
    function automatic logic wild_resolve(input fld_class_t c);
        logic found;
        logic res;
        found = 1'b0;
        res   = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && (c.star[i] || (!c.qmark[i] && c.term[i])))
            begin
                found = 1'b1;
                res   = c.star[i] || c.hit[i];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dewf_classify.sv =====
// Stage 1 of the filter: field masking, byte compares and entry flags.
// Depends on dewf_pkg.
`default_nettype none

module dewf_classify
    import dewf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] entry_name,
    input  wire logic [23:0] entry_ext,
    input  wire logic [7:0]  entry_attrib,
    input  wire logic [15:0] entry_cluster,
    input  wire logic [31:0] entry_size,
    input  wire logic [63:0] name_pattern,
    input  wire logic [23:0] ext_pattern,
    output logic             s1_valid,
    output s1_t              s1_data
);

    logic        s1_valid_reg;
    s1_t         s1_data_reg;
    s1_t         s1_data_next;
    logic [63:0] nm_masked;
    logic [63:0] ex_masked;
    logic [63:0] np_masked;
    logic [63:0] ep_masked;

    // Field ends: entry at space or zero, pattern at zero
    always_comb
    begin
        nm_masked = mask_field(entry_name, 1'b1);
        ex_masked = mask_field({40'h0, entry_ext}, 1'b1);
        np_masked = mask_field(name_pattern, 1'b0);
        ep_masked = mask_field({40'h0, ext_pattern}, 1'b0);
    end

    // Classes and raw-byte flags
    always_comb
    begin
        s1_data_next.name_c          = classify_field(np_masked, nm_masked);
        s1_data_next.ext_c           = classify_field(ep_masked, ex_masked);
        s1_data_next.ext_pat_empty   = (ext_pattern[7:0] == 8'h00);
        s1_data_next.ext_first_space = (entry_ext[7:0] == CH_SPACE);
        s1_data_next.long_name       = (entry_name[23:16] == 8'h00) &&
                                       (entry_name[39:32] == 8'h00) &&
                                       (entry_name[55:48] == 8'h00) &&
                                       (entry_ext[7:0] == 8'h00) &&
                                       (entry_ext[23:16] == 8'h00);
        s1_data_next.dir_end         = (entry_name[7:0] == 8'h00);
        s1_data_next.deleted         = (entry_name[7:0] == CH_DELETED);
        s1_data_next.attrib          = entry_attrib;
        s1_data_next.cluster         = entry_cluster;
        s1_data_next.size            = entry_size;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
            s1_data_reg <= s1_data_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dewf_resolve.sv =====
// Stage 2 of the filter: wildcard walk and exact/empty rules per field.
// Depends on dewf_pkg.
`default_nettype none

module dewf_resolve
    import dewf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s1_valid,
    input  wire s1_t  s1_data,
    output logic      s2_valid,
    output s2_t       s2_data
);

    logic s2_valid_reg;
    s2_t  s2_data_reg;
    s2_t  s2_data_next;

    always_comb
    begin
        // Name: wildcard walk, else exact
        s2_data_next.name_ok = s1_data.name_c.wild ? wild_resolve(s1_data.name_c)
                                                   : s1_data.name_c.exact;
        // Extension: blank entry against empty pattern, walk, exact, else no match
        if (s1_data.ext_first_space && s1_data.ext_pat_empty)
            s2_data_next.ext_ok = 1'b1;
        else if (s1_data.ext_c.wild)
            s2_data_next.ext_ok = wild_resolve(s1_data.ext_c);
        else if (!s1_data.ext_pat_empty)
            s2_data_next.ext_ok = s1_data.ext_c.exact;
        else
            s2_data_next.ext_ok = 1'b0;
        s2_data_next.long_name = s1_data.long_name;
        s2_data_next.dir_end   = s1_data.dir_end;
        s2_data_next.deleted   = s1_data.deleted;
        s2_data_next.attrib    = s1_data.attrib;
        s2_data_next.cluster   = s1_data.cluster;
        s2_data_next.size      = s1_data.size;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_valid)
            s2_data_reg <= s2_data_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2_data  = s2_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dir_entry_wildcard_filter_core.sv =====
// Top level of the directory entry wildcard filter: config registers, final stage.
// Depends on dewf_pkg, dewf_classify and dewf_resolve.
//
//  channel   handshake               payload
//  --------  ----------------------  ---------------------------------------------
//  entry     start, busy (always 0)  entry_name, entry_ext, entry_attrib,
//                                    entry_cluster, entry_size
//  result    result_valid (1 cycle)  is_match, dir_end, long_name_entry,
//                                    out_attrib, out_cluster, out_size
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One entry per cycle. Each entry passes the classify, resolve and output registers in
// that order, one result strobe per transaction.
// The result side cannot stall, so the pipeline never holds and busy stays low.
// Reset clears the stage valid bits and loads the pattern registers ("*.*",
// skip deleted). Config writes are taken at any time, one per cycle.
`default_nettype none

module dir_entry_wildcard_filter_core
    import dewf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // entry transaction
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [63:0]          entry_name,
    input  wire logic [23:0]          entry_ext,
    input  wire logic [7:0]           entry_attrib,
    input  wire logic [15:0]          entry_cluster,
    input  wire logic [31:0]          entry_size,
    // result transaction
    output logic                      result_valid,
    output logic                      is_match,
    output logic                      dir_end,
    output logic                      long_name_entry,
    output logic [7:0]                out_attrib,
    output logic [15:0]               out_cluster,
    output logic [31:0]               out_size,
    // config write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    logic [63:0] name_pat_reg;
    logic [23:0] ext_pat_reg;
    logic        skip_deleted_reg;
    logic        in_valid;
    logic        s1_valid;
    s1_t         s1_data;
    logic        s2_valid;
    s2_t         s2_data;
    logic        out_valid_reg;
    logic        match_next;
    logic        is_match_reg;
    logic        dir_end_reg;
    logic        long_name_reg;
    logic [7:0]  attrib_reg;
    logic [15:0] cluster_reg;
    logic [31:0] size_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // Configuration registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_pat_reg     <= NAME_PATTERN_RST;
            ext_pat_reg      <= EXT_PATTERN_RST;
            skip_deleted_reg <= SKIP_DELETED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NAME_PATTERN: name_pat_reg     <= cfg_data;
                CFG_EXT_PATTERN:  ext_pat_reg      <= cfg_data[23:0];
                CFG_SKIP_DELETED: skip_deleted_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Stage 1
    dewf_classify u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .entry_name    (entry_name),
        .entry_ext     (entry_ext),
        .entry_attrib  (entry_attrib),
        .entry_cluster (entry_cluster),
        .entry_size    (entry_size),
        .name_pattern  (name_pat_reg),
        .ext_pattern   (ext_pat_reg),
        .s1_valid      (s1_valid),
        .s1_data       (s1_data)
    );

    // Stage 2
    dewf_resolve u_resolve (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_data  (s2_data)
    );

    // Stage 3: entry rejection rules
    assign match_next = s2_data.name_ok && s2_data.ext_ok && !s2_data.long_name &&
                        !s2_data.dir_end && !(s2_data.deleted && skip_deleted_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid)
        begin
            is_match_reg  <= match_next;
            dir_end_reg   <= s2_data.dir_end;
            long_name_reg <= s2_data.long_name;
            attrib_reg    <= s2_data.attrib;
            cluster_reg   <= s2_data.cluster;
            size_reg      <= s2_data.size;
        end
    end

    assign result_valid    = out_valid_reg;
    assign is_match        = is_match_reg;
    assign dir_end         = dir_end_reg;
    assign long_name_entry = long_name_reg;
    assign out_attrib      = attrib_reg;
    assign out_cluster     = cluster_reg;
    assign out_size        = size_reg;

    // Every accepted entry yields a result after the classify, resolve and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##3 result_valid)
        else $error("entry transaction lost in pipeline");

    // No result without an entry accepted ahead of it at the pipeline input
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(in_valid, 3))
        else $error("result transaction without entry");

    // Long-name and end-of-directory entries never match
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_match) |-> (!long_name_entry && !dir_end))
        else $error("rejected entry reported as match");

    // Passthrough fields follow the entry
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##3 (out_size == $past(entry_size, 3)))
        else $error("size field corrupted in pipeline");

endmodule

`default_nettype wire

// ===== sim/dir_entry_wildcard_filter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dir_entry_wildcard_filter_core: a directed table of entries,
// then random directory entries under several pattern settings, checked by an 8.3 matcher.
// Depends on dewf_pkg and the filter RTL.

module dir_entry_wildcard_filter_core_tb;
    import dewf_pkg::*;

    typedef struct packed {
        logic [63:0] name;
        logic [23:0] ext;
        logic [7:0]  attrib;
        logic [15:0] cluster;
        logic [31:0] size;
    } dir_entry_t;

    typedef struct packed {
        logic        is_match;
        logic        dir_end;
        logic        long_name;
        logic [7:0]  attrib;
        logic [15:0] cluster;
        logic [31:0] size;
    } verdict_t;

    // One directed row: pattern setting, entry, and a hand-typed verdict where known
    typedef struct packed {
        logic [63:0] name_pat;
        logic [23:0] ext_pat;
        logic        skip;
        logic        known;
        verdict_t    typed;
        dir_entry_t  entry;
    } table_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [63:0]          entry_name = '0;
    logic [23:0]          entry_ext = '0;
    logic [7:0]           entry_attrib = '0;
    logic [15:0]          entry_cluster = '0;
    logic [31:0]          entry_size = '0;
    logic                 result_valid;
    logic                 is_match;
    logic                 dir_end;
    logic                 long_name_entry;
    logic [7:0]           out_attrib;
    logic [15:0]          out_cluster;
    logic [31:0]          out_size;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    // Bench copy of the filter registers
    logic [63:0] pat_name = NAME_PATTERN_RST;
    logic [23:0] pat_ext = EXT_PATTERN_RST;
    logic        skip_del = SKIP_DELETED_RST;

    verdict_t    pending_verdicts[$];
    table_row_t  entry_table[$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          pace_gaps = 1'b0;

    // Row builder state
    logic [63:0] row_np;
    logic [23:0] row_ep;
    logic        row_sk;

    dir_entry_wildcard_filter_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .entry_name      (entry_name),
        .entry_ext       (entry_ext),
        .entry_attrib    (entry_attrib),
        .entry_cluster   (entry_cluster),
        .entry_size      (entry_size),
        .result_valid    (result_valid),
        .is_match        (is_match),
        .dir_end         (dir_end),
        .long_name_entry (long_name_entry),
        .out_attrib      (out_attrib),
        .out_cluster     (out_cluster),
        .out_size        (out_size),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- 8.3 matcher

    // Bytes before the first zero, or the first space when asked
    function automatic int field_len(logic [63:0] v, int n, bit stop_space);
        for (int i = 0; i < n; i++)
        begin
            if (v[8*i +: 8] == 8'h00 || (stop_space && v[8*i +: 8] == CH_SPACE))
                return i;
        end
        return n;
    endfunction

    function automatic bit has_wildcard(logic [63:0] p, int plen);
        for (int i = 0; i < plen; i++)
        begin
            if (p[8*i +: 8] == CH_STAR || p[8*i +: 8] == CH_QMARK)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit same_field(logic [63:0] p, int plen, logic [63:0] s, int slen);
        if (plen != slen)
            return 1'b0;
        for (int i = 0; i < plen; i++)
        begin
            if (p[8*i +: 8] != s[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Walk a fixed number of positions; bytes past either end read as zero
    function automatic bit wild_walk(logic [63:0] p, int plen, logic [63:0] s, int slen,
                                     int steps);
        logic [7:0] pc;
        logic [7:0] sc;
        for (int i = 0; i < steps; i++)
        begin
            pc = (i < plen) ? p[8*i +: 8] : 8'h00;
            sc = (i < slen) ? s[8*i +: 8] : 8'h00;
            if (pc == CH_STAR)
                return 1'b1;
            if (pc != CH_QMARK)
            begin
                if (pc != sc)
                    return 1'b0;
                if (pc == 8'h00)
                    return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic verdict_t screen_entry(dir_entry_t e);
        verdict_t    v;
        logic [63:0] ext_s;
        logic [63:0] ext_p;
        int          nlen;
        int          elen;
        int          nplen;
        int          eplen;
        bit          name_ok;
        bit          ext_ok;
        ext_s = {40'h0, e.ext};
        ext_p = {40'h0, pat_ext};
        v.long_name = (e.name[23:16] == 8'h00) && (e.name[39:32] == 8'h00) &&
                      (e.name[55:48] == 8'h00) && (e.ext[7:0] == 8'h00) &&
                      (e.ext[23:16] == 8'h00);
        v.dir_end = (e.name[7:0] == 8'h00);
        nlen  = field_len(e.name, 8, 1'b1);
        elen  = field_len(ext_s, 3, 1'b1);
        nplen = field_len(pat_name, 8, 1'b0);
        eplen = field_len(ext_p, 3, 1'b0);

        if (has_wildcard(pat_name, nplen))
            name_ok = wild_walk(pat_name, nplen, e.name, nlen, 8);
        else
            name_ok = same_field(pat_name, nplen, e.name, nlen);

        // empty pattern only takes an extension that starts with a space
        if (e.ext[7:0] == CH_SPACE && eplen == 0)
            ext_ok = 1'b1;
        else if (has_wildcard(ext_p, eplen))
            ext_ok = wild_walk(ext_p, eplen, ext_s, elen, 4);
        else if (eplen > 0)
            ext_ok = same_field(ext_p, eplen, ext_s, elen);
        else
            ext_ok = 1'b0;

        v.is_match = name_ok && ext_ok && !v.long_name && !v.dir_end &&
                     !(e.name[7:0] == CH_DELETED && skip_del);
        v.attrib  = e.attrib;
        v.cluster = e.cluster;
        v.size    = e.size;
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Text to little-endian bytes, padded with the given byte
    function automatic logic [63:0] text_bytes(string s, int n, logic [7:0] pad);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
            r[8*i +: 8] = (i < s.len()) ? s[i] : pad;
        return r;
    endfunction

    function automatic logic [23:0] ext_text(string s, logic [7:0] pad);
        logic [63:0] t;
        t = text_bytes(s, 3, pad);
        return t[23:0];
    endfunction

    // Mostly a tiny alphabet so patterns and entries collide often
    function automatic logic [7:0] small_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            c = 8'($urandom_range(33, 255));
        else
            c = 8'($urandom_range(65, 67));
        return c;
    endfunction

    function automatic logic [63:0] rand_pattern(int n);
        logic [63:0] r;
        int          len;
        int          pick;
        int          sel;
        r    = '0;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r = {$urandom, $urandom};
        else if (pick == 1)
        begin
            for (int i = 0; i < n; i++)
                r[8*i +: 8] = CH_QMARK;
        end
        else
        begin
            len = $urandom_range(0, n);
            for (int i = 0; i < len; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    r[8*i +: 8] = small_char();
                else if (sel < 7)
                    r[8*i +: 8] = CH_QMARK;
                else if (sel < 9)
                    r[8*i +: 8] = CH_STAR;
                else
                    r[8*i +: 8] = CH_DELETED;
            end
        end
        if (n == 3)
            r[63:24] = '0;
        return r;
    endfunction

    // Entry field that follows a pattern, sometimes with one byte spoiled
    function automatic logic [63:0] gen_field(logic [63:0] pat, int n);
        logic [63:0] r;
        logic [7:0]  pc;
        int          plen;
        int          pos;
        int          sel;
        bit          tail;
        r    = '0;
        tail = 1'b0;
        plen = field_len(pat, n, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            pc = pat[8*i +: 8];
            if (tail)
                r[8*i +: 8] = ($urandom_range(0, 2) == 0) ? CH_SPACE : small_char();
            else if (i >= plen)
                r[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : CH_SPACE;
            else if (pc == CH_STAR)
            begin
                tail = 1'b1;
                r[8*i +: 8] = ($urandom_range(0, 2) == 0) ? CH_SPACE : small_char();
            end
            else if (pc == CH_QMARK)
                r[8*i +: 8] = ($urandom_range(0, 5) == 0) ? CH_SPACE : small_char();
            else
                r[8*i +: 8] = pc;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            pos = $urandom_range(0, n - 1);
            sel = $urandom_range(0, 2);
            r[8*pos +: 8] = (sel == 0) ? small_char() : (sel == 1) ? CH_SPACE : 8'h00;
        end
        return r;
    endfunction

    function automatic dir_entry_t make_entry();
        dir_entry_t  e;
        logic [63:0] x;
        logic [31:0] w;
        int          kind;
        kind   = $urandom_range(0, 99);
        e.name = gen_field(pat_name, 8);
        x      = gen_field({40'h0, pat_ext}, 3);
        e.ext  = x[23:0];
        w = $urandom;
        e.attrib  = w[7:0];
        e.cluster = w[31:16];
        e.size    = $urandom;
        if (kind < 60)
            ;
        else if (kind < 70)
        begin
            e.name = {$urandom, $urandom};
            w      = $urandom;
            e.ext  = w[23:0];
        end
        else if (kind < 77)
            e.name[7:0] = CH_DELETED;
        else if (kind < 83)
        begin
            // long-name entry
            e.name[23:16] = 8'h00;
            e.name[39:32] = 8'h00;
            e.name[55:48] = 8'h00;
            e.ext[7:0]    = 8'h00;
            e.ext[23:16]  = 8'h00;
        end
        else if (kind < 88)
            e.name[7:0] = 8'h00;
        else
        begin
            // noise unrelated to the current pattern
            e.name = gen_field(rand_pattern(8), 8);
            x      = gen_field(rand_pattern(3), 3);
            e.ext  = x[23:0];
        end
        return e;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_NAME_PATTERN)
            pat_name = data;
        else if (idx == CFG_EXT_PATTERN)
            pat_ext = data[23:0];
        else if (idx == CFG_SKIP_DELETED)
            skip_del = data[0];
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
            mismatches++;
            pending_verdicts.delete();
        end
    endtask

    // One entry transaction, with burst/gap pacing ahead of it
    task automatic issue_entry(dir_entry_t e, bit known, verdict_t typed);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (pace_gaps)
                pause($urandom_range(1, 7));
        end
        burst_left--;
        start         <= 1'b1;
        entry_name    <= e.name;
        entry_ext     <= e.ext;
        entry_attrib  <= e.attrib;
        entry_cluster <= e.cluster;
        entry_size    <= e.size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_verdicts.push_back(known ? typed : screen_entry(e));
    endtask

    task automatic reconfigure(logic [63:0] np, logic [23:0] ep, logic sk);
        pause(0);
        wait_idle();
        cfg_write(CFG_NAME_PATTERN, np);
        cfg_write(CFG_EXT_PATTERN, {40'h0, ep});
        cfg_write(CFG_SKIP_DELETED, {63'h0, sk});
    endtask

    task automatic row_cfg(logic [63:0] np, logic [23:0] ep, logic sk);
        row_np = np;
        row_ep = ep;
        row_sk = sk;
    endtask

    task automatic add_row(logic [63:0] nm, logic [23:0] ex, logic [7:0] at, logic [15:0] cl,
                           logic [31:0] sz, bit known, bit m, bit d, bit l);
        table_row_t r;
        r.name_pat      = row_np;
        r.ext_pat       = row_ep;
        r.skip          = row_sk;
        r.known         = known;
        r.entry.name    = nm;
        r.entry.ext     = ex;
        r.entry.attrib  = at;
        r.entry.cluster = cl;
        r.entry.size    = sz;
        r.typed.is_match  = m;
        r.typed.dir_end   = d;
        r.typed.long_name = l;
        r.typed.attrib    = at;
        r.typed.cluster   = cl;
        r.typed.size      = sz;
        entry_table.push_back(r);
    endtask

    // ---------------------------------------------------------------- result checker

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_valid)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing actual match=%0b",
                         $time, is_match);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("is_match", 32'(want.is_match), 32'(is_match));
                check_field("dir_end", 32'(want.dir_end), 32'(dir_end));
                check_field("long_name_entry", 32'(want.long_name), 32'(long_name_entry));
                check_field("out_attrib", 32'(want.attrib), 32'(out_attrib));
                check_field("out_cluster", 32'(want.cluster), 32'(out_cluster));
                check_field("out_size", want.size, out_size);
            end
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        table_row_t r;
        logic [63:0] np;
        logic [63:0] ep;
        logic        sk;

        // directed table
        row_cfg(NAME_PATTERN_RST, EXT_PATTERN_RST, SKIP_DELETED_RST);
        add_row(text_bytes("README", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h20, 16'h0000, 32'h0000_0000, 1, 1, 0, 0);
        add_row(64'h0, 24'h0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1, 1);
        add_row(64'h0100_0100_0100_0141, 24'h00FF00, 8'h0F, 16'h0002, 32'h0000_0001,
                1, 0, 0, 1);
        add_row(64'h2020_2045_4C49_46E5, ext_text("TXT", CH_SPACE),
                8'h20, 16'h1234, 32'h0000_1000, 1, 0, 0, 0);
        // deleted entries compared as plain characters
        row_cfg(NAME_PATTERN_RST, EXT_PATTERN_RST, 1'b0);
        add_row(64'h2020_2045_4C49_46E5, ext_text("TXT", CH_SPACE),
                8'h01, 16'h00FF, 32'h0001_0000, 0, 0, 0, 0);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 8'h80, 16'h8000, 32'h8000_0000,
                0, 0, 0, 0);
        // exact compare
        row_cfg(text_bytes("README", 8, 8'h00), ext_text("TXT", 8'h00), 1'b1);
        add_row(text_bytes("README", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h20, 16'h0010, 32'h0000_0200, 0, 0, 0, 0);
        add_row(text_bytes("READ", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h20, 16'h0011, 32'h0000_0201, 0, 0, 0, 0);
        add_row(text_bytes("README", 8, CH_SPACE), ext_text("TX", CH_SPACE),
                8'h20, 16'h0012, 32'h0000_0202, 0, 0, 0, 0);
        add_row(text_bytes("readme", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h20, 16'h0013, 32'h0000_0203, 0, 0, 0, 0);
        // mixed wildcards
        row_cfg(text_bytes("R?AD*", 8, 8'h00), ext_text("T?T", 8'h00), 1'b1);
        add_row(text_bytes("ROADMAP", 8, CH_SPACE), ext_text("TAT", CH_SPACE),
                8'h10, 16'h0100, 32'h0000_0000, 0, 0, 0, 0);
        add_row(text_bytes("RAD", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h10, 16'h0101, 32'h0000_0000, 0, 0, 0, 0);
        // all question marks, question mark against the field end
        row_cfg(text_bytes("????????", 8, 8'h00), ext_text("???", 8'h00), 1'b1);
        add_row(text_bytes("A", 8, CH_SPACE), ext_text("", CH_SPACE),
                8'h00, 16'h0200, 32'h0000_0010, 0, 0, 0, 0);
        add_row(text_bytes("ABCDEFGH", 8, CH_SPACE), ext_text("XYZ", CH_SPACE),
                8'h00, 16'h0201, 32'h0000_0011, 0, 0, 0, 0);
        row_cfg(text_bytes("ABC?", 8, 8'h00), ext_text("*", 8'h00), 1'b1);
        add_row(text_bytes("ABC", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h00, 16'h0300, 32'h0000_0020, 0, 0, 0, 0);
        // empty extension pattern
        row_cfg(text_bytes("*", 8, 8'h00), 24'h0, 1'b1);
        add_row(text_bytes("A", 8, CH_SPACE), ext_text("", CH_SPACE),
                8'h00, 16'h0400, 32'h0000_0030, 0, 0, 0, 0);
        add_row(text_bytes("A", 8, CH_SPACE), 24'h0,
                8'h00, 16'h0401, 32'h0000_0031, 0, 0, 0, 0);
        add_row(text_bytes("A", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h00, 16'h0402, 32'h0000_0032, 0, 0, 0, 0);
        // empty name pattern against a blank name
        row_cfg(64'h0, ext_text("*", 8'h00), 1'b1);
        add_row(text_bytes("", 8, CH_SPACE), ext_text("TXT", CH_SPACE),
                8'h00, 16'h0500, 32'h0000_0040, 0, 0, 0, 0);
        // full-length pattern with no terminator
        row_cfg(text_bytes("ABCDEFGH", 8, 8'h00), ext_text("ABC", 8'h00), 1'b1);
        add_row(text_bytes("ABCDEFGH", 8, CH_SPACE), ext_text("ABC", CH_SPACE),
                8'h00, 16'h0600, 32'h0000_0050, 0, 0, 0, 0);
        add_row(text_bytes("ABCDEFG", 8, CH_SPACE), ext_text("ABC", CH_SPACE),
                8'h00, 16'h0601, 32'h0000_0051, 0, 0, 0, 0);
        // all-ones registers
        row_cfg(64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 1'b1);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 8'h7F, 16'h7FFF, 32'h7FFF_FFFF,
                0, 0, 0, 0);
        add_row(text_bytes("A", 8, CH_SPACE), ext_text("", CH_SPACE),
                8'h7F, 16'h7FFE, 32'h7FFF_FFFE, 0, 0, 0, 0);
        // star after a literal in the extension
        row_cfg(text_bytes("*", 8, 8'h00), ext_text("T*", 8'h00), 1'b0);
        add_row(text_bytes("X", 8, CH_SPACE), ext_text("T", CH_SPACE),
                8'h00, 16'h0700, 32'h0000_0060, 0, 0, 0, 0);

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back
        pace_gaps  = 1'b0;
        burst_left = 0;
        foreach (entry_table[i])
        begin
            r = entry_table[i];
            if (r.name_pat != pat_name || r.ext_pat != pat_ext || r.skip != skip_del)
                reconfigure(r.name_pat, r.ext_pat, r.skip);
            issue_entry(r.entry, r.known, r.typed);
        end

        // random part: one pattern setting per phase
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                np = NAME_PATTERN_RST;
                ep = {40'h0, EXT_PATTERN_RST};
                sk = SKIP_DELETED_RST;
            end
            else if (phase == 1)
            begin
                np = '0;
                ep = '0;
                sk = 1'b0;
            end
            else if (phase == 2)
            begin
                np = '1;
                ep = 64'hFF_FFFF;
                sk = 1'b1;
            end
            else
            begin
                np = rand_pattern(8);
                ep = rand_pattern(3);
                sk = 1'($urandom_range(0, 1));
            end
            reconfigure(np, ep[23:0], sk);
            pace_gaps  = (phase % 3 != 1);
            burst_left = 0;
            for (int k = 0; k < 131; k++)
                issue_entry(make_entry(), 1'b0, '0);
        end

        // drain
        pause(0);
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
